// ===== hdl/tic_pkg.sv =====
`default_nettype none

package tic_pkg;

	localparam int unsigned TIC_COUNT_WIDTH_DEF = 32;
	localparam int unsigned TIC_CHANNELS_DEF    = 4;

	localparam int unsigned TIC_DATA_W   = 32;
	localparam int unsigned TIC_FLAGS_W  = 5;
	localparam int unsigned TIC_PINS_W   = 4;
	localparam int unsigned TIC_CHAN_W   = 2;
	localparam int unsigned TIC_REQ_W    = 3;
	localparam int unsigned TIC_SDATA_W  = 40;
	localparam int unsigned TIC_MDATA_W  = 40;
	localparam int unsigned TIC_CFG_IDX_W = 3;

	typedef enum logic [TIC_REQ_W-1:0] {
		REQ_TICK      = 3'd0,
		REQ_READ_CNT  = 3'd1,
		REQ_READ_CAP  = 3'd2,
		REQ_WRITE_CNT = 3'd3,
		REQ_CLEAR     = 3'd4,
		REQ_RUN_CTRL  = 3'd5
	} req_t;

	typedef enum logic [TIC_CFG_IDX_W-1:0] {
		CFG_PRESCALE   = 3'd0,
		CFG_MATCH      = 3'd1,
		CFG_RISE_EN    = 3'd2,
		CFG_FALL_EN    = 3'd3,
		CFG_CAP_IRQ_EN = 3'd4,
		CFG_MAT_IRQ_EN = 3'd5
	} cfg_idx_t;

	localparam logic [TIC_DATA_W-1:0] RUN_STOP  = 32'd0;
	localparam logic [TIC_DATA_W-1:0] RUN_START = 32'd1;
	localparam logic [TIC_DATA_W-1:0] RUN_RESET = 32'd2;

	typedef struct packed {
		logic [TIC_DATA_W-1:0] prescale;
		logic [TIC_DATA_W-1:0] match_value;
		logic [TIC_PINS_W-1:0] rise_enable;
		logic [TIC_PINS_W-1:0] fall_enable;
		logic [TIC_PINS_W-1:0] capture_irq_enable;
		logic                  match_irq_enable;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/tic_regs.sv =====
`default_nettype none

module tic_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [tic_pkg::TIC_CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tic_pkg::TIC_DATA_W-1:0]    cfg_wdata,
	output tic_pkg::cfg_t                           cfg
);
	import tic_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prescale           <= '0;
			cfg_q.match_value        <= '1;
			cfg_q.rise_enable        <= '0;
			cfg_q.fall_enable        <= '0;
			cfg_q.capture_irq_enable <= '0;
			cfg_q.match_irq_enable   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PRESCALE:   cfg_q.prescale           <= cfg_wdata;
				CFG_MATCH:      cfg_q.match_value        <= cfg_wdata;
				CFG_RISE_EN:    cfg_q.rise_enable        <= cfg_wdata[TIC_PINS_W-1:0];
				CFG_FALL_EN:    cfg_q.fall_enable        <= cfg_wdata[TIC_PINS_W-1:0];
				CFG_CAP_IRQ_EN: cfg_q.capture_irq_enable <= cfg_wdata[TIC_PINS_W-1:0];
				CFG_MAT_IRQ_EN: cfg_q.match_irq_enable   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/timer_input_capture_unit.sv =====
`default_nettype none

// Up-counting timer with prescaler, match wrap and input capture on up to four
// pins. Every transaction (tick, counter/capture read, counter write, flag clear,
// run control) is taken into an input register, handled there and returns
// one result from the output register: one transaction per clock unless
// m_tready stalls the output register. Counter, prescaler, capture and flag
// registers update as a transaction is handled. The result carries read data
// (zero for non-read requests), the pending flags after the request (bit 0 match
// wrap, bits 1 and up capture channels) and the masked interrupt. Flags are
// write-one-to-clear; a start command clears them all.
module timer_input_capture_unit #(
	parameter int unsigned COUNT_WIDTH = tic_pkg::TIC_COUNT_WIDTH_DEF,
	parameter int unsigned CHANNELS    = tic_pkg::TIC_CHANNELS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	// pin_levels[3:0], channel[5:4], data[37:6], zero pad
	input  wire logic [tic_pkg::TIC_SDATA_W-1:0]   s_tdata,
	// req_type[2:0]
	input  wire logic [tic_pkg::TIC_REQ_W-1:0]     s_tuser,
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	// read_data[31:0], flags[36:32], irq[37], zero pad
	output      logic [tic_pkg::TIC_MDATA_W-1:0]   m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [tic_pkg::TIC_CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tic_pkg::TIC_DATA_W-1:0]    cfg_wdata
);
	import tic_pkg::*;

	localparam int unsigned FLAG_W = CHANNELS + 1;

	cfg_t cfg;

	tic_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register
	logic                  valid_s1;
	req_t                  req_s1;
	logic [TIC_PINS_W-1:0] pins_s1;
	logic [TIC_CHAN_W-1:0] chan_s1;
	logic [TIC_DATA_W-1:0] data_s1;

	// timer state
	logic [TIC_DATA_W-1:0]  presc_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] cap_q [CHANNELS];
	logic [FLAG_W-1:0]      flag_q;
	logic [CHANNELS-1:0]    prev_q;
	logic                   run_q;

	// result register
	logic                   out_valid_q;
	logic [TIC_DATA_W-1:0]  out_rd_q;
	logic [TIC_FLAGS_W-1:0] out_flags_q;
	logic                   out_irq_q;

	logic                   adv;
	logic                   proc;

	logic [TIC_DATA_W-1:0]  presc_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic [FLAG_W-1:0]      flag_d;
	logic [CHANNELS-1:0]    prev_d;
	logic                   run_d;
	logic [CHANNELS-1:0]    cap_we;
	logic [COUNT_WIDTH-1:0] rd;
	logic                   irq_d;
	logic [CHANNELS-1:0]    pins;
	logic [CHANNELS-1:0]    hit;

	assign adv      = !out_valid_q || m_tready;
	assign proc     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	assign pins = pins_s1[CHANNELS-1:0];
	assign hit  = ((pins & ~prev_q) & cfg.rise_enable[CHANNELS-1:0])
		| ((~pins & prev_q) & cfg.fall_enable[CHANNELS-1:0]);

	always_comb begin
		presc_d = presc_q;
		count_d = count_q;
		flag_d  = flag_q;
		prev_d  = prev_q;
		run_d   = run_q;
		cap_we  = '0;
		rd      = '0;
		case (req_s1)
			REQ_TICK: begin
				// captures take the count from before this tick's advance
				cap_we = hit;
				flag_d = flag_q | {hit, 1'b0};
				prev_d = pins;
				if (run_q) begin
					if (presc_q >= cfg.prescale) begin
						presc_d = '0;
						if (count_q == cfg.match_value[COUNT_WIDTH-1:0]) begin
							count_d   = '0;
							flag_d[0] = 1'b1;
						end else begin
							count_d = count_q + COUNT_WIDTH'(1);
						end
					end else begin
						presc_d = presc_q + TIC_DATA_W'(1);
					end
				end
			end
			REQ_READ_CNT: rd = count_q;
			REQ_READ_CAP: begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (chan_s1 == TIC_CHAN_W'(i)) rd = cap_q[i];
				end
			end
			REQ_WRITE_CNT: begin
				count_d = data_s1[COUNT_WIDTH-1:0];
				presc_d = '0;
			end
			REQ_CLEAR: flag_d = flag_q & ~data_s1[FLAG_W-1:0];
			REQ_RUN_CTRL: begin
				if (data_s1 == RUN_STOP) begin
					run_d = 1'b0;
				end else if (data_s1 == RUN_START) begin
					run_d  = 1'b1;
					flag_d = '0;
				end else if (data_s1 == RUN_RESET) begin
					count_d = '0;
					presc_d = '0;
				end
			end
			default: ;
		endcase
		irq_d = (flag_d[0] & cfg.match_irq_enable)
			| (|(flag_d[CHANNELS:1] & cfg.capture_irq_enable[CHANNELS-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= req_t'(s_tuser);
			pins_s1 <= s_tdata[3:0];
			chan_s1 <= s_tdata[5:4];
			data_s1 <= s_tdata[37:6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
			count_q <= '0;
			flag_q  <= '0;
			prev_q  <= '0;
			run_q   <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) cap_q[i] <= '0;
		end else if (proc) begin
			presc_q <= presc_d;
			count_q <= count_d;
			flag_q  <= flag_d;
			prev_q  <= prev_d;
			run_q   <= run_d;
			for (int i = 0; i < CHANNELS; i++) begin
				if (cap_we[i]) cap_q[i] <= count_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_rd_q    <= TIC_DATA_W'(rd);
			out_flags_q <= TIC_FLAGS_W'(flag_d);
			out_irq_q   <= irq_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_irq_q, out_flags_q, out_rd_q};

	// a counter write always restarts the prescaler
	a_wr_clears_presc: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && req_s1 == REQ_WRITE_CNT) |=> (presc_q == '0))
		else $error("prescaler not cleared by counter write");

	// start leaves the timer running with no pending flags
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && req_s1 == REQ_RUN_CTRL && data_s1 == RUN_START)
		|=> (run_q && flag_q == '0))
		else $error("start did not clear flags or set running");

	// a stalled input stage keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(req_s1) && $stable(data_s1)))
		else $error("input stage lost a stalled transaction");

endmodule

`default_nettype wire

// ===== verif/tb_timer_input_capture_unit.sv =====
`default_nettype none

module tb_timer_input_capture_unit;
	import tic_pkg::*;

	localparam logic [TIC_REQ_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [TIC_REQ_W-1:0] REQ_SPARE7 = 3'd7;

	localparam int DIR_ROWS        = 26;
	localparam int DIR_CFG_ROW     = 14;
	localparam int NUM_PHASES      = 9;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_OFF_CYCLES = 60;

	typedef struct packed {
		logic [TIC_REQ_W-1:0]  req;
		logic [TIC_PINS_W-1:0] pins;
		logic [TIC_CHAN_W-1:0] chan;
		logic [TIC_DATA_W-1:0] data;
	} request_t;

	typedef struct packed {
		logic [TIC_DATA_W-1:0]  rd;
		logic [TIC_FLAGS_W-1:0] flags;
		logic                   irq;
	} report_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		report_t  rep;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [TIC_SDATA_W-1:0]    s_tdata;
	logic [TIC_REQ_W-1:0]      s_tuser;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [TIC_MDATA_W-1:0]    m_tdata;
	logic                      cfg_we;
	logic [TIC_CFG_IDX_W-1:0]  cfg_index;
	logic [TIC_DATA_W-1:0]     cfg_wdata;

	timer_input_capture_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// timer shadow state
	cfg_t                   cur_cfg;
	logic [TIC_DATA_W-1:0]  p_count;
	logic [TIC_DATA_W-1:0]  p_presc;
	logic [TIC_DATA_W-1:0]  p_caps [4];
	logic [TIC_FLAGS_W-1:0] p_flags;
	logic [TIC_PINS_W-1:0]  p_pins;
	logic                   p_running;

	report_t                pending_reports [$];
	int                     err_count;
	logic                   tx_idle;
	logic                   rx_idle;
	int                     hold_req;
	logic [TIC_PINS_W-1:0]  pin_walk;

	// request, pins, chan, data, expected report where it is obvious
	dir_row_t dir_table [DIR_ROWS] = '{
		'{'{REQ_READ_CNT,  4'h0, 2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_READ_CAP,  4'h0, 2'd3, 32'h0000_0000}, 1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_TICK,      4'hF, 2'd0, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_READ_CNT,  4'h0, 2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_RUN_CTRL,  4'h0, 2'd0, RUN_START},     1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_TICK,      4'h0, 2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_READ_CNT,  4'h0, 2'd0, 32'h0000_0000}, 1'b1, '{32'h1, 5'h00, 1'b0}},
		'{'{REQ_WRITE_CNT, 4'h0, 2'd0, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_TICK,      4'h0, 2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 5'h01, 1'b0}},
		'{'{REQ_READ_CNT,  4'h0, 2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 5'h01, 1'b0}},
		'{'{REQ_SPARE6,    4'hF, 2'd3, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 5'h01, 1'b0}},
		'{'{REQ_SPARE7,    4'hF, 2'd3, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 5'h01, 1'b0}},
		'{'{REQ_CLEAR,     4'h0, 2'd0, 32'hFFFF_FFE0}, 1'b1, '{32'h0, 5'h01, 1'b0}},
		'{'{REQ_CLEAR,     4'h0, 2'd0, 32'h0000_0001}, 1'b1, '{32'h0, 5'h00, 1'b0}},
		'{'{REQ_TICK,      4'hF, 2'd0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_TICK,      4'h0, 2'd0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_READ_CAP,  4'h0, 2'd0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_READ_CAP,  4'h0, 2'd3, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_WRITE_CNT, 4'h0, 2'd0, 32'hFFFF_FFFF}, 1'b0, '0},
		'{'{REQ_TICK,      4'h0, 2'd0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_TICK,      4'h0, 2'd0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_READ_CNT,  4'h0, 2'd0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_RUN_CTRL,  4'h0, 2'd0, 32'h0000_0003}, 1'b0, '0},
		'{'{REQ_RUN_CTRL,  4'h0, 2'd0, RUN_RESET},     1'b0, '0},
		'{'{REQ_RUN_CTRL,  4'h0, 2'd0, RUN_STOP},      1'b0, '0},
		'{'{REQ_RUN_CTRL,  4'h0, 2'd0, RUN_START},     1'b0, '0}
	};

	function automatic report_t timer_step(input request_t it);
		report_t                rep;
		logic [TIC_PINS_W-1:0]  rising;
		logic [TIC_PINS_W-1:0]  falling;
		logic [TIC_PINS_W-1:0]  hit;
		rep = '0;
		case (it.req)
			REQ_TICK: begin
				rising  = it.pins & ~p_pins;
				falling = ~it.pins & p_pins;
				hit = (rising & cur_cfg.rise_enable) | (falling & cur_cfg.fall_enable);
				// captures take the count from before this tick's advance
				for (int ch = 0; ch < 4; ch++) begin
					if (hit[ch]) begin
						p_caps[ch]     = p_count;
						p_flags[ch + 1] = 1'b1;
					end
				end
				p_pins = it.pins;
				if (p_running) begin
					if (p_presc >= cur_cfg.prescale) begin
						p_presc = '0;
						if (p_count == cur_cfg.match_value) begin
							p_count    = '0;
							p_flags[0] = 1'b1;
						end else begin
							p_count = p_count + 32'd1;
						end
					end else begin
						p_presc = p_presc + 32'd1;
					end
				end
			end
			REQ_READ_CNT: rep.rd = p_count;
			REQ_READ_CAP: rep.rd = p_caps[it.chan];
			REQ_WRITE_CNT: begin
				p_count = it.data;
				p_presc = '0;
			end
			REQ_CLEAR: p_flags = p_flags & ~it.data[TIC_FLAGS_W-1:0];
			REQ_RUN_CTRL: begin
				if (it.data == RUN_STOP) begin
					p_running = 1'b0;
				end else if (it.data == RUN_START) begin
					p_flags   = '0;
					p_running = 1'b1;
				end else if (it.data == RUN_RESET) begin
					p_count = '0;
					p_presc = '0;
				end
			end
			default: ;
		endcase
		rep.flags = p_flags;
		rep.irq   = (p_flags[0] & cur_cfg.match_irq_enable) |
			(|(p_flags[4:1] & cur_cfg.capture_irq_enable));
		return rep;
	endfunction

	function automatic request_t gen_request();
		request_t    it;
		int unsigned pick;
		it.pins = 4'($urandom);
		it.chan = 2'($urandom);
		it.data = $urandom;
		pick    = $urandom_range(0, 99);
		if (pick < 58) begin
			it.req = REQ_TICK;
			// mostly walk one pin at a time so single edges dominate
			if ($urandom_range(0, 4) == 0)
				pin_walk = 4'($urandom);
			else
				pin_walk = pin_walk ^ 4'(1 << $urandom_range(0, 3));
			it.pins = pin_walk;
		end else if (pick < 70) begin
			it.req = REQ_READ_CNT;
		end else if (pick < 78) begin
			it.req = REQ_READ_CAP;
		end else if (pick < 84) begin
			it.req = REQ_WRITE_CNT;
			case ($urandom_range(0, 3))
				0, 1: it.data = cur_cfg.match_value - 32'($urandom_range(0, 3));
				2: it.data = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
				default: ;
			endcase
		end else if (pick < 91) begin
			it.req = REQ_CLEAR;
		end else if (pick < 99) begin
			it.req = REQ_RUN_CTRL;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: it.data = RUN_START;
				5, 6: it.data = RUN_STOP;
				7, 8: it.data = RUN_RESET;
				default: ;
			endcase
		end else begin
			it.req = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
		end
		return it;
	endfunction

	function automatic cfg_t phase_config(input int ph);
		cfg_t c;
		c.prescale           = 32'($urandom_range(0, 3));
		c.match_value        = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 40));
		c.rise_enable        = 4'($urandom);
		c.fall_enable        = 4'($urandom);
		c.capture_irq_enable = 4'($urandom);
		c.match_irq_enable   = 1'($urandom);
		case (ph)
			0: c = '{32'h0, 32'h0, 4'hF, 4'hF, 4'hF, 1'b1};
			1: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 4'h0, 4'h0, 1'b0};
			2: c = '{32'h0, 32'hFFFF_FFFF, 4'hF, 4'h0, 4'h5, 1'b1};
			default: ;
		endcase
		return c;
	endfunction

	task automatic offer_request(input request_t it, input logic typed, input report_t typed_rep);
		int      gap;
		report_t rep;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, it.data, it.chan, it.pins};
		s_tuser  <= it.req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		rep = timer_step(it);
		pending_reports.push_back(typed ? typed_rep : rep);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [TIC_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		cfg_write(CFG_PRESCALE, c.prescale);
		cfg_write(CFG_MATCH, c.match_value);
		cfg_write(CFG_RISE_EN, 32'(c.rise_enable));
		cfg_write(CFG_FALL_EN, 32'(c.fall_enable));
		cfg_write(CFG_CAP_IRQ_EN, 32'(c.capture_irq_enable));
		cfg_write(CFG_MAT_IRQ_EN, 32'(c.match_irq_enable));
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3200000;
		$display("Verification failed");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int      stall;
		report_t got;
		report_t want;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				stall    = hold_req;
				hold_req = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 7) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.rd    = m_tdata[31:0];
			got.flags = m_tdata[36:32];
			got.irq   = m_tdata[37];
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $time, got);
				err_count++;
			end else begin
				want = pending_reports.pop_front();
				if (got.rd !== want.rd) begin
					$display("%0t: read_data expected %h actual %h", $time, want.rd, got.rd);
					err_count++;
				end
				if (got.flags !== want.flags) begin
					$display("%0t: flags expected %h actual %h", $time, want.flags, got.flags);
					err_count++;
				end
				if (got.irq !== want.irq) begin
					$display("%0t: irq expected %b actual %b", $time, want.irq, got.irq);
					err_count++;
				end
			end
		end
	end

	initial begin
		cfg_t dir_cfg;
		cfg_t c;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		err_count = 0;
		hold_req  = 0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		pin_walk  = '0;
		cur_cfg   = '{32'h0, 32'hFFFF_FFFF, 4'h0, 4'h0, 4'h0, 1'b0};
		p_count   = '0;
		p_presc   = '0;
		p_flags   = '0;
		p_pins    = '0;
		p_running = 1'b0;
		for (int ch = 0; ch < 4; ch++) p_caps[ch] = '0;
		dir_cfg = '{32'h1, 32'h3, 4'h5, 4'hA, 4'h3, 1'b1};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_CFG_ROW) begin
				wait_idle();
				load_config(dir_cfg);
			end
			offer_request(dir_table[i].req, dir_table[i].typed, dir_table[i].rep);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			c = phase_config(ph);
			wait_idle();
			load_config(c);
			tx_idle = (ph % 3) != 1;
			rx_idle = (ph % 3) != 2;
			// keep offering at full rate while the result side holds off
			if (ph == PRESSURE_PHASE) begin
				tx_idle  = 1'b0;
				hold_req = HOLD_OFF_CYCLES;
			end
			repeat (ITEMS_PER_PHASE) offer_request(gen_request(), 1'b0, '0);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0 && pending_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== timer_input_capture_unit.f =====
hdl/tic_pkg.sv
hdl/tic_regs.sv
hdl/timer_input_capture_unit.sv
verif/tb_timer_input_capture_unit.sv
